>>> hw/rtl/ttyexp_pkg.sv
// ----------------------------------------------------------------------------
// ttyexp_pkg
// shared types, character codes and command encodings for the terminal
// output character expander
// ----------------------------------------------------------------------------
package ttyexp_pkg;

  localparam int COLUMN_BITS = 8;

  typedef logic [COLUMN_BITS-1:0] column_t;
  typedef logic [COLUMN_BITS:0]   column_wide_t;

  localparam logic [6:0] CH_EOT    = 7'h04;
  localparam logic [6:0] CH_BS     = 7'h08;
  localparam logic [6:0] CH_TAB    = 7'h09;
  localparam logic [6:0] CH_NL     = 7'h0a;
  localparam logic [6:0] CH_VT     = 7'h0b;
  localparam logic [6:0] CH_FF     = 7'h0c;
  localparam logic [6:0] CH_CR     = 7'h0d;
  localparam logic [6:0] CH_SPACE  = 7'h20;
  localparam logic [6:0] CH_BSLASH = 7'h5c;
  localparam logic [6:0] CH_LOW_A  = 7'h61;
  localparam logic [6:0] CH_LOW_Z  = 7'h7a;
  localparam logic [6:0] CH_TILDE  = 7'h7e;
  localparam logic [6:0] CH_DEL    = 7'h7f;
  localparam logic [6:0] CASE_DIFF = 7'h20;
  localparam logic [6:0] DELAY_MAX = 7'h7f;

  // newline delay kinds
  localparam logic [1:0] NL_COLUMN  = 2'd1;
  localparam logic [1:0] NL_FIXED   = 2'd2;
  // tab delay kinds
  localparam logic [1:0] TAB_COLUMN = 2'd1;
  localparam logic [1:0] TAB_EXPAND = 2'd3;
  // return delay kinds
  localparam logic [1:0] CR_DELAY5  = 2'd1;
  localparam logic [1:0] CR_DELAY10 = 2'd2;
  localparam logic [1:0] CR_FILL    = 2'd3;

  typedef enum logic [2:0] {
    REG_RAW, REG_CBREAK, REG_UPPER, REG_CRLF,
    REG_NL_DELAY, REG_TAB_DELAY, REG_CR_DELAY, REG_VERT_DELAY
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEND, ST_FILL, ST_DELAY, ST_SPACE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_ACCEPT, OP_SEND, OP_FILL, OP_DELAY, OP_SPACE
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic room;
    logic drop;
    logic expand;
    logic fill;
    logic dly;
    logic pend;
    logic more;
    logic cnt_one;
    logic cnt_zero;
  } status_t;

  // upper-case terminal escapes: {hit, replacement}
  function automatic logic [7:0] esc_map(input logic [6:0] c);
    logic [7:0] r;
    r = {1'b0, c};
    case (c)
      7'h7b: r = {1'b1, 7'h28};
      7'h7d: r = {1'b1, 7'h29};
      7'h7c: r = {1'b1, 7'h21};
      7'h7e: r = {1'b1, 7'h5e};
      7'h60: r = {1'b1, 7'h27};
      default: r = {1'b0, c};
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/ttyexp_ctrl.sv
// ----------------------------------------------------------------------------
// ttyexp_ctrl
// sequencer that steps one character through its byte run
// ----------------------------------------------------------------------------
module ttyexp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  ttyexp_pkg::status_t sts,
  output ttyexp_pkg::cmd_t    cmd,
  output ttyexp_pkg::state_t  state
);

  ttyexp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttyexp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = ttyexp_pkg::OP_NONE;
    s_tready   = 1'b0;
    case (state)
      ttyexp_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op = ttyexp_pkg::OP_ACCEPT;
          if (sts.drop) begin
            state_next = ttyexp_pkg::ST_IDLE;
          end else if (sts.expand) begin
            state_next = ttyexp_pkg::ST_SPACE;
          end else begin
            state_next = ttyexp_pkg::ST_SEND;
          end
        end
      end
      ttyexp_pkg::ST_SEND: begin
        if (sts.room) begin
          cmd.op = ttyexp_pkg::OP_SEND;
          if (sts.fill) begin
            state_next = ttyexp_pkg::ST_FILL;
          end else if (sts.dly) begin
            state_next = ttyexp_pkg::ST_DELAY;
          end else if (sts.pend) begin
            state_next = ttyexp_pkg::ST_SEND;
          end else begin
            state_next = ttyexp_pkg::ST_IDLE;
          end
        end
      end
      ttyexp_pkg::ST_FILL: begin
        if (sts.room) begin
          cmd.op = ttyexp_pkg::OP_FILL;
          if (sts.cnt_one) begin
            state_next = sts.more ? ttyexp_pkg::ST_SEND : ttyexp_pkg::ST_IDLE;
          end
        end
      end
      ttyexp_pkg::ST_DELAY: begin
        if (sts.room) begin
          cmd.op     = ttyexp_pkg::OP_DELAY;
          state_next = sts.more ? ttyexp_pkg::ST_SEND : ttyexp_pkg::ST_IDLE;
        end
      end
      ttyexp_pkg::ST_SPACE: begin
        if (sts.room) begin
          cmd.op = ttyexp_pkg::OP_SPACE;
          if (sts.cnt_one) begin
            state_next = ttyexp_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ttyexp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/ttyexp_dp.sv
// ----------------------------------------------------------------------------
// ttyexp_dp
// mode registers, column tracking, character translation and output register
// ----------------------------------------------------------------------------
module ttyexp_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [1:0]          cfg_data,
  input  logic [7:0]          s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast,
  input  ttyexp_pkg::cmd_t    cmd,
  output ttyexp_pkg::status_t sts
);

  logic       raw_mode;
  logic       cbreak_mode;
  logic       upper_case_terminal;
  logic       crlf_mode;
  logic [1:0] newline_delay_kind;
  logic [1:0] tab_delay_kind;
  logic [1:0] return_delay_kind;
  logic       vertical_delay;

  ttyexp_pkg::column_t column;
  logic [7:0]          ch;
  logic [6:0]          main_ch;
  logic                pend;
  logic                more;
  logic                raw_item;
  logic [3:0]          cnt;
  logic [6:0]          dly;

  // input decode
  logic [6:0] c7;
  logic [7:0] esc;
  logic [6:0] folded;
  logic       in_drop;
  logic       in_expand;
  logic       in_crlf;

  // send decode
  ttyexp_pkg::column_t      col_new;
  ttyexp_pkg::column_wide_t nl_d;
  logic [3:0]               tab_d;
  logic [3:0]               snd_fill;
  logic [6:0]               snd_dly;
  logic                     send_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode            <= 1'b0;
      cbreak_mode         <= 1'b0;
      upper_case_terminal <= 1'b0;
      crlf_mode           <= 1'b0;
      newline_delay_kind  <= 2'd0;
      tab_delay_kind      <= 2'd0;
      return_delay_kind   <= 2'd0;
      vertical_delay      <= 1'b0;
    end else if (cfg_we) begin
      case (ttyexp_pkg::reg_index_t'(cfg_index))
        ttyexp_pkg::REG_RAW:        raw_mode            <= cfg_data[0];
        ttyexp_pkg::REG_CBREAK:     cbreak_mode         <= cfg_data[0];
        ttyexp_pkg::REG_UPPER:      upper_case_terminal <= cfg_data[0];
        ttyexp_pkg::REG_CRLF:       crlf_mode           <= cfg_data[0];
        ttyexp_pkg::REG_NL_DELAY:   newline_delay_kind  <= cfg_data;
        ttyexp_pkg::REG_TAB_DELAY:  tab_delay_kind      <= cfg_data;
        ttyexp_pkg::REG_CR_DELAY:   return_delay_kind   <= cfg_data;
        ttyexp_pkg::REG_VERT_DELAY: vertical_delay      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    c7        = s_tdata[6:0];
    in_drop   = !raw_mode && !cbreak_mode && (c7 == ttyexp_pkg::CH_EOT);
    in_expand = !raw_mode && (c7 == ttyexp_pkg::CH_TAB) &&
                (tab_delay_kind == ttyexp_pkg::TAB_EXPAND);
    esc       = upper_case_terminal ? ttyexp_pkg::esc_map(c7) : {1'b0, c7};
    folded    = esc[6:0];
    if (upper_case_terminal &&
        (esc[6:0] inside {[ttyexp_pkg::CH_LOW_A:ttyexp_pkg::CH_LOW_Z]})) begin
      folded = esc[6:0] - ttyexp_pkg::CASE_DIFF;
    end
    in_crlf = crlf_mode && (folded == ttyexp_pkg::CH_NL);
  end

  always_comb begin
    col_new  = column;
    snd_fill = 4'd0;
    snd_dly  = 7'd0;
    nl_d     = {1'b0, column >> 4} + ttyexp_pkg::column_wide_t'(3);
    tab_d    = 4'd9 - {1'b0, column[2:0]};
    if (nl_d < ttyexp_pkg::column_wide_t'(6)) begin
      nl_d = ttyexp_pkg::column_wide_t'(6);
    end
    if (nl_d > ttyexp_pkg::column_wide_t'(ttyexp_pkg::DELAY_MAX)) begin
      nl_d = ttyexp_pkg::column_wide_t'(ttyexp_pkg::DELAY_MAX);
    end
    if (!raw_item) begin
      case (ch[6:0]) inside
        [ttyexp_pkg::CH_SPACE:ttyexp_pkg::CH_TILDE]: begin
          col_new = ttyexp_pkg::column_t'(column + 1'b1);
        end
        ttyexp_pkg::CH_BS: begin
          if (column != '0) begin
            col_new = ttyexp_pkg::column_t'(column - 1'b1);
          end
        end
        ttyexp_pkg::CH_NL: begin
          if (newline_delay_kind == ttyexp_pkg::NL_COLUMN) begin
            if (column != '0) begin
              snd_dly = nl_d[6:0];
            end
          end else if (newline_delay_kind == ttyexp_pkg::NL_FIXED) begin
            snd_dly = 7'd6;
          end
          col_new = '0;
        end
        ttyexp_pkg::CH_TAB: begin
          if (tab_delay_kind == ttyexp_pkg::TAB_COLUMN && tab_d >= 4'd5) begin
            snd_dly = {3'b000, tab_d};
          end
          col_new = ttyexp_pkg::column_t'((column | ttyexp_pkg::column_t'(7)) + 1'b1);
        end
        ttyexp_pkg::CH_VT, ttyexp_pkg::CH_FF: begin
          if (vertical_delay) begin
            snd_dly = ttyexp_pkg::DELAY_MAX;
          end
        end
        ttyexp_pkg::CH_CR: begin
          if (return_delay_kind == ttyexp_pkg::CR_DELAY5) begin
            snd_dly = 7'd5;
          end else if (return_delay_kind == ttyexp_pkg::CR_DELAY10) begin
            snd_dly = 7'd10;
          end else if (return_delay_kind == ttyexp_pkg::CR_FILL) begin
            if (column < ttyexp_pkg::column_t'(9)) begin
              snd_fill = 4'd9 - column[3:0];
            end
          end
          col_new = '0;
        end
        default: ;
      endcase
    end
    send_last = (snd_fill == 4'd0) && (snd_dly == 7'd0) && !pend;
  end

  always_comb begin
    sts.room     = !m_tvalid || m_tready;
    sts.drop     = in_drop;
    sts.expand   = in_expand;
    sts.fill     = snd_fill != 4'd0;
    sts.dly      = snd_dly != 7'd0;
    sts.pend     = pend;
    sts.more     = more;
    sts.cnt_one  = cnt == 4'd1;
    sts.cnt_zero = cnt == 4'd0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      column   <= '0;
      pend     <= 1'b0;
      more     <= 1'b0;
      raw_item <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (cmd.op)
        ttyexp_pkg::OP_ACCEPT: begin
          raw_item <= raw_mode;
          more     <= 1'b0;
          pend     <= !raw_mode && !in_expand && (esc[7] || in_crlf);
        end
        ttyexp_pkg::OP_SEND: begin
          m_tvalid <= 1'b1;
          column   <= col_new;
          pend     <= 1'b0;
          more     <= pend;
        end
        ttyexp_pkg::OP_FILL, ttyexp_pkg::OP_DELAY: begin
          m_tvalid <= 1'b1;
        end
        ttyexp_pkg::OP_SPACE: begin
          m_tvalid <= 1'b1;
          column   <= ttyexp_pkg::column_t'(column + 1'b1);
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      ttyexp_pkg::OP_ACCEPT: begin
        main_ch <= folded;
        cnt     <= 4'd8 - {1'b0, column[2:0]};
        if (raw_mode) begin
          ch <= s_tdata;
        end else if (esc[7]) begin
          ch <= {1'b0, ttyexp_pkg::CH_BSLASH};
        end else if (in_crlf) begin
          ch <= {1'b0, ttyexp_pkg::CH_CR};
        end else begin
          ch <= {1'b0, folded};
        end
      end
      ttyexp_pkg::OP_SEND: begin
        m_tdata <= ch;
        m_tlast <= send_last;
        cnt     <= snd_fill;
        dly     <= snd_dly;
        if (pend) begin
          ch <= {1'b0, main_ch};
        end
      end
      ttyexp_pkg::OP_FILL: begin
        m_tdata <= {1'b0, ttyexp_pkg::CH_DEL};
        m_tlast <= (cnt == 4'd1) && !more;
        cnt     <= cnt - 4'd1;
      end
      ttyexp_pkg::OP_DELAY: begin
        m_tdata <= {1'b1, dly};
        m_tlast <= !more;
      end
      ttyexp_pkg::OP_SPACE: begin
        m_tdata <= {1'b0, ttyexp_pkg::CH_SPACE};
        m_tlast <= cnt == 4'd1;
        cnt     <= cnt - 4'd1;
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/tty_output_char_expander.sv
// ----------------------------------------------------------------------------
// tty_output_char_expander
// expands one terminal character into the run of bytes to transmit
// ----------------------------------------------------------------------------
// input is taken only in idle; the send or space state that follows loads the
// first byte of a run into the output register; a run has up to 12 bytes, sent
//   one byte per cycle out of the sequencer while the output has room
// output stalls hold the sequencer; the output register frees the input side
// reset: synchronous, clears modes, column, sequencer and output valid
module tty_output_char_expander (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [1:0] cfg_data,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // char_in
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tlast    // last_byte
);

  ttyexp_pkg::cmd_t    cmd;
  ttyexp_pkg::status_t sts;
  ttyexp_pkg::state_t  state;

  ttyexp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  ttyexp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

  // a counted run never starts with an empty count
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ttyexp_pkg::ST_FILL || state == ttyexp_pkg::ST_SPACE) |-> !sts.cnt_zero)
    else $error("run count is zero in a counted state");

  // an idle sequencer only leaves the final byte of a run waiting
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    (state == ttyexp_pkg::ST_IDLE && m_tvalid) |-> m_tlast)
    else $error("idle with a non-final byte pending");

  // returning to idle always follows loading the final byte
  a_end_of_run: assert property (@(posedge clk) disable iff (rst)
    (state == ttyexp_pkg::ST_IDLE && $past(state) != ttyexp_pkg::ST_IDLE && !$past(rst))
    |-> (m_tvalid && m_tlast))
    else $error("run ended without a final byte");

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the terminal output character expander against a cycle-free
// predictor: characters are streamed in bursts under a series of mode
// settings, and every output byte and its run marker are compared in order
// ----------------------------------------------------------------------------
module testbench;

  localparam int STALL_LIMIT = 2000;
  localparam int MAX_RUN     = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_t;

  typedef struct packed {
    logic       raw;
    logic       cbreak;
    logic       upper;
    logic       crlf;
    logic [1:0] nl;
    logic [1:0] tab;
    logic [1:0] cr;
    logic       vert;
  } tty_mode_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [1:0] cfg_data = '0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  logic [7:0] pending_chars[$];
  tx_t        expected_bytes[$];
  tx_t        run_bytes[$];

  tty_mode_t           cur_mode = '0;
  ttyexp_pkg::column_t print_col = '0;

  int chars_taken = 0;
  int bytes_seen = 0;
  int modes_used = 0;
  int errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  int ready_cycle = 0;
  int ready_style = 0;
  int quiet_cycles = 0;

  logic [7:0] plain_chars [0:11] = '{8'h00, 8'hff, 8'h04, 8'h84, 8'h08, 8'h61,
                                     8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h7e};
  logic [7:0] upper_chars [0:11] = '{8'h04, 8'h7b, 8'h7d, 8'h7c, 8'h7e, 8'h60,
                                     8'h7a, 8'h0a, 8'h0d, 8'h0a, 8'h09, 8'h0b};

  tty_output_char_expander dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void put_out(input logic [7:0] b);
    tx_t t;
    t = '0;
    t.data = b;
    if (run_bytes.size() < MAX_RUN) run_bytes.push_back(t);
  endfunction

  // one 7-bit character, its column effect and its trailing delay
  function automatic void emit_char(input logic [6:0] c);
    logic [7:0] dly;
    int i;
    dly = '0;
    put_out({1'b0, c});
    if (c >= ttyexp_pkg::CH_SPACE && c <= ttyexp_pkg::CH_TILDE) begin
      print_col = print_col + 1'b1;
    end else if (c == ttyexp_pkg::CH_BS) begin
      if (print_col != 0) print_col = print_col - 1'b1;
    end else if (c == ttyexp_pkg::CH_NL) begin
      if (cur_mode.nl == ttyexp_pkg::NL_COLUMN) begin
        if (print_col != 0) begin
          dly = 8'(print_col >> 4) + 8'd3;
          if (dly < 8'd6) dly = 8'd6;
          if (dly > {1'b0, ttyexp_pkg::DELAY_MAX}) dly = {1'b0, ttyexp_pkg::DELAY_MAX};
        end
      end else if (cur_mode.nl == ttyexp_pkg::NL_FIXED) begin
        dly = 8'd6;
      end
      print_col = '0;
    end else if (c == ttyexp_pkg::CH_TAB) begin
      if (cur_mode.tab == ttyexp_pkg::TAB_COLUMN) begin
        dly = 8'd9 - {5'd0, print_col[2:0]};
        if (dly < 8'd5) dly = '0;
      end
      print_col = (print_col | ttyexp_pkg::column_t'(7)) + 1'b1;
    end else if (c == ttyexp_pkg::CH_VT || c == ttyexp_pkg::CH_FF) begin
      if (cur_mode.vert) dly = {1'b0, ttyexp_pkg::DELAY_MAX};
    end else if (c == ttyexp_pkg::CH_CR) begin
      if (cur_mode.cr == ttyexp_pkg::CR_DELAY5) begin
        dly = 8'd5;
      end else if (cur_mode.cr == ttyexp_pkg::CR_DELAY10) begin
        dly = 8'd10;
      end else if (cur_mode.cr == ttyexp_pkg::CR_FILL) begin
        for (i = int'(print_col); i < 9; i++) put_out({1'b0, ttyexp_pkg::CH_DEL});
      end
      print_col = '0;
    end
    if (dly != 0) put_out(dly | 8'h80);
  endfunction

  function automatic void expand_char(input logic [7:0] ch);
    logic [6:0] c;
    logic [6:0] rep;
    logic       esc;
    int         k;
    int         cnt;
    tx_t        t;
    run_bytes.delete();
    c = ch[6:0];
    if (cur_mode.raw) begin
      put_out(ch);
    end else if (!cur_mode.cbreak && c == ttyexp_pkg::CH_EOT) begin
      // dropped
    end else if (c == ttyexp_pkg::CH_TAB && cur_mode.tab == ttyexp_pkg::TAB_EXPAND) begin
      cnt = 8 - int'(print_col[2:0]);
      for (k = 0; k < cnt; k++) put_out({1'b0, ttyexp_pkg::CH_SPACE});
      print_col = print_col + ttyexp_pkg::column_t'(cnt);
    end else begin
      if (cur_mode.upper) begin
        esc = 1'b1;
        rep = c;
        case (c)
          7'h7b: rep = 7'h28;
          7'h7d: rep = 7'h29;
          7'h7c: rep = 7'h21;
          7'h7e: rep = 7'h5e;
          7'h60: rep = 7'h27;
          default: esc = 1'b0;
        endcase
        if (esc) begin
          emit_char(ttyexp_pkg::CH_BSLASH);
          c = rep;
        end
        if (c >= ttyexp_pkg::CH_LOW_A && c <= ttyexp_pkg::CH_LOW_Z) begin
          c = c - ttyexp_pkg::CASE_DIFF;
        end
      end
      if (c == ttyexp_pkg::CH_NL && cur_mode.crlf) emit_char(ttyexp_pkg::CH_CR);
      emit_char(c);
    end
    for (k = 0; k < run_bytes.size(); k++) begin
      t = run_bytes[k];
      t.last = (k == run_bytes.size() - 1);
      expected_bytes.push_back(t);
    end
  endfunction

  function automatic logic [7:0] random_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c = 8'($urandom_range(8'h20, 8'h7e));
      4, 5: begin
        case ($urandom_range(0, 6))
          0: c = {1'b0, ttyexp_pkg::CH_BS};
          1: c = {1'b0, ttyexp_pkg::CH_TAB};
          2: c = {1'b0, ttyexp_pkg::CH_NL};
          3: c = {1'b0, ttyexp_pkg::CH_VT};
          4: c = {1'b0, ttyexp_pkg::CH_FF};
          5: c = {1'b0, ttyexp_pkg::CH_CR};
          default: c = {1'b0, ttyexp_pkg::CH_EOT};
        endcase
      end
      6: begin
        case ($urandom_range(0, 6))
          0: c = 8'h7b;
          1: c = 8'h7d;
          2: c = 8'h7c;
          3: c = 8'h7e;
          4: c = 8'h60;
          5: c = 8'($urandom_range(8'h61, 8'h7a));
          default: c = 8'($urandom_range(8'h41, 8'h5a));
        endcase
      end
      7: c = 8'($urandom_range(0, 255));
      8: c = 8'($urandom_range(0, 31));
      default: c = {1'b0, ttyexp_pkg::CH_DEL};
    endcase
    if ($urandom_range(0, 3) == 0) c[7] = 1'b1;
    return c;
  endfunction

  task automatic set_mode(input tty_mode_t m);
    int                     r;
    ttyexp_pkg::reg_index_t idx;
    logic [1:0]             v;
    for (r = 0; r < 8; r++) begin
      idx = ttyexp_pkg::reg_index_t'(r);
      case (idx)
        ttyexp_pkg::REG_RAW:       v = {1'b0, m.raw};
        ttyexp_pkg::REG_CBREAK:    v = {1'b0, m.cbreak};
        ttyexp_pkg::REG_UPPER:     v = {1'b0, m.upper};
        ttyexp_pkg::REG_CRLF:      v = {1'b0, m.crlf};
        ttyexp_pkg::REG_NL_DELAY:  v = m.nl;
        ttyexp_pkg::REG_TAB_DELAY: v = m.tab;
        ttyexp_pkg::REG_CR_DELAY:  v = m.cr;
        default:                   v = {1'b0, m.vert};
      endcase
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= v;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mode = m;
    modes_used++;
  endtask

  task automatic drain();
    while (pending_chars.size() != 0 || s_tvalid) @(negedge clk);
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // stimulus
  initial begin
    int        ph;
    int        n;
    int        len;
    tty_mode_t m;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    foreach (plain_chars[i]) pending_chars.push_back(plain_chars[i]);
    drain();

    set_mode('{raw: 1'b0, cbreak: 1'b1, upper: 1'b1, crlf: 1'b1,
               nl: ttyexp_pkg::NL_COLUMN, tab: ttyexp_pkg::TAB_COLUMN,
               cr: ttyexp_pkg::CR_FILL, vert: 1'b1});
    @(negedge clk);
    foreach (upper_chars[i]) pending_chars.push_back(upper_chars[i]);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: m = '0;
        1: m = '{raw: 1'b0, cbreak: 1'b1, upper: 1'b1, crlf: 1'b1,
                 nl: 2'd3, tab: ttyexp_pkg::TAB_EXPAND, cr: ttyexp_pkg::CR_FILL,
                 vert: 1'b1};
        2: m = '1;
        3: m = '{raw: 1'b0, cbreak: 1'b0, upper: 1'b1, crlf: 1'b1,
                 nl: ttyexp_pkg::NL_FIXED, tab: 2'd2, cr: ttyexp_pkg::CR_DELAY5,
                 vert: 1'b0};
        default: begin
          m = tty_mode_t'($urandom);
          m.raw = ($urandom_range(0, 4) == 0);
        end
      endcase
      set_mode(m);
      @(negedge clk);
      n = 0;
      // enough tabs to wrap the column
      if (ph == 1) begin
        repeat (34) pending_chars.push_back({1'b0, ttyexp_pkg::CH_TAB});
        n = 34;
      end
      while (n < 60) begin
        if ($urandom_range(0, 9) == 0) begin
          len = $urandom_range(10, 50);
          repeat (len) begin
            if ($urandom_range(0, 3) == 0) begin
              pending_chars.push_back({1'b0, ttyexp_pkg::CH_TAB});
            end else begin
              pending_chars.push_back(8'($urandom_range(8'h20, 8'h7e)));
            end
          end
          n += len;
        end else begin
          pending_chars.push_back(random_char());
          n++;
        end
      end
      drain();
    end

    repeat (16) @(negedge clk);
    if (expected_bytes.size() != 0) begin
      errors++;
      $display("%0d expected bytes never arrived", expected_bytes.size());
    end
    $display("sent %0d characters under %0d mode settings, checked %0d output bytes",
             chars_taken, modes_used, bytes_seen);
    $display("errors: %0d", errors);
    if (errors == 0) begin
      $display("tty_output_char_expander test passed");
    end else begin
      $display("tty_output_char_expander test failed");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expand_char(s_tdata);
        chars_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_chars.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tx_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        bytes_seen++;
        if (expected_bytes.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected output byte %h last %b", m_tdata, m_tlast);
        end else begin
          e = expected_bytes.pop_front();
          if (m_tdata !== e.data || m_tlast !== e.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected byte %h last %b, got byte %h last %b",
                       e.data, e.last, m_tdata, m_tlast);
          end
        end
      end
      ready_cycle++;
      if (ready_cycle % 96 == 0) ready_style = $urandom_range(0, 2);
      case (ready_style)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ((ready_cycle % 7) < 3);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("tty_output_char_expander test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> filelist.f
hw/rtl/ttyexp_pkg.sv
hw/rtl/ttyexp_ctrl.sv
hw/rtl/ttyexp_dp.sv
hw/rtl/tty_output_char_expander.sv
bench/testbench.sv
